// ----- design/atatf_pkg.sv -----
// ----------------------------------------------------------------------------
// ATA task-file issuer package
// Shared types, register offsets, task-file byte codes and the constants of
// the CHS address split.
// ----------------------------------------------------------------------------
package atatf_pkg;

  // Request field widths
  localparam int ADDR_W  = 48;
  localparam int COUNT_W = 8;
  localparam int MASK_W  = 4;
  localparam int OFF_W   = 3;
  localparam int BYTE_W  = 8;

  // Addresses at or above 2**28 need 48-bit addressing
  localparam int LBA28_W = 28;

  // addr / 63 as (addr * RECIP63) >> RECIP_SHIFT, exact for any 28-bit addr
  localparam int              RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP63  = 29'd272696337;
  localparam int              RECIP_SHIFT = 34;
  localparam int              PROD_W      = LBA28_W + RECIP_W;
  localparam int              QUOT_W      = 23;

  // Port blocks
  localparam logic BLK_CMD  = 1'b0;
  localparam logic BLK_CTRL = 1'b1;

  // Register offsets
  localparam logic [OFF_W-1:0] OFF_DEV_CTRL  = 3'd2;
  localparam logic [OFF_W-1:0] OFF_SECCOUNT  = 3'd2;
  localparam logic [OFF_W-1:0] OFF_LBA0      = 3'd3;
  localparam logic [OFF_W-1:0] OFF_LBA1      = 3'd4;
  localparam logic [OFF_W-1:0] OFF_LBA2      = 3'd5;
  localparam logic [OFF_W-1:0] OFF_DRV_HEAD  = 3'd6;
  localparam logic [OFF_W-1:0] OFF_COMMAND   = 3'd7;

  // Byte codes
  localparam logic [BYTE_W-1:0] CTRL_NIEN     = 8'h02;
  localparam logic [BYTE_W-1:0] CTRL_HOB_NIEN = 8'h82;
  localparam logic [BYTE_W-1:0] SEL_CHS       = 8'hA0;
  localparam logic [BYTE_W-1:0] SEL_LBA       = 8'hE0;
  localparam logic [BYTE_W-1:0] CMD_READ      = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_READ_EXT  = 8'h24;
  localparam logic [BYTE_W-1:0] CMD_WRITE     = 8'h30;
  localparam logic [BYTE_W-1:0] CMD_WRITE_EXT = 8'h34;

  typedef enum logic [1:0] {
    MODE_CHS,
    MODE_LBA28,
    MODE_LBA48
  } mode_t;

  // One entry per task-file write of the longest (48-bit) run
  typedef enum logic [4:0] {
    STP_NIEN,
    STP_SELECT,
    STP_HOB_CNT,
    STP_HI_CNT,
    STP_LOB_CNT,
    STP_HOB_L3,
    STP_HI_L3,
    STP_LOB_L3,
    STP_HOB_L4,
    STP_HI_L4,
    STP_LOB_L4,
    STP_HOB_L5,
    STP_HI_L5,
    STP_LOB_L5,
    STP_COUNT,
    STP_LBA0,
    STP_LBA1,
    STP_LBA2,
    STP_CMD
  } step_t;

  // Decoded command handed to the sequencer
  typedef struct packed {
    logic              channel;
    mode_t             mode;
    logic [BYTE_W-1:0] count;
    logic [BYTE_W-1:0] select;
    logic [BYTE_W-1:0] lba0;
    logic [BYTE_W-1:0] lba1;
    logic [BYTE_W-1:0] lba2;
    logic [BYTE_W-1:0] lba3;
    logic [BYTE_W-1:0] lba4;
    logic [BYTE_W-1:0] lba5;
    logic [BYTE_W-1:0] opcode;
  } cmd_t;

endpackage

// ----- design/atatf_decode.sv -----
// ----------------------------------------------------------------------------
// ATA task-file request decode
// Two-stage pipeline: capture the request and pick the addressing mode, then
// divide the address by 63 and build the task-file bytes of the command.
// ----------------------------------------------------------------------------
module atatf_decode (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [atatf_pkg::MASK_W-1:0]     lba_capable_mask,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [atatf_pkg::ADDR_W-1:0]     in_block_address,
  input  logic [atatf_pkg::COUNT_W-1:0]    in_sector_count,
  input  logic                             in_is_write,
  input  logic                             in_drive_select,
  input  logic                             in_channel_select,
  output logic                             cmd_valid,
  input  logic                             cmd_ready,
  output atatf_pkg::cmd_t                  cmd
);

  // Stage 1 registers
  logic                             s1_valid_r;
  logic [atatf_pkg::ADDR_W-1:0]     s1_addr_r;
  logic [atatf_pkg::COUNT_W-1:0]    s1_count_r;
  logic                             s1_wr_r;
  logic                             s1_drv_r;
  logic                             s1_ch_r;
  atatf_pkg::mode_t                 s1_mode_r;

  // Stage 2 registers
  logic                             s2_valid_r;
  logic [atatf_pkg::ADDR_W-1:0]     s2_addr_r;
  logic [atatf_pkg::COUNT_W-1:0]    s2_count_r;
  logic                             s2_wr_r;
  logic                             s2_drv_r;
  logic                             s2_ch_r;
  atatf_pkg::mode_t                 s2_mode_r;
  logic [atatf_pkg::QUOT_W-1:0]     s2_quot_r;

  logic                             s1_ready;
  logic                             s2_ready;
  atatf_pkg::mode_t                 in_mode;
  logic [atatf_pkg::PROD_W-1:0]     prod;
  logic [atatf_pkg::LBA28_W-1:0]    rem;
  logic [atatf_pkg::BYTE_W-1:0]     sector;
  logic [3:0]                       head;

  // Backpressure: a stage takes new data when empty or draining
  assign s2_ready = !s2_valid_r || cmd_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Pick the addressing mode from the address range and the drive's bit
  always_comb begin
    if (in_block_address[atatf_pkg::ADDR_W-1:atatf_pkg::LBA28_W] != '0) begin
      in_mode = atatf_pkg::MODE_LBA48;
    end else if (lba_capable_mask[{in_channel_select, in_drive_select}]) begin
      in_mode = atatf_pkg::MODE_LBA28;
    end else begin
      in_mode = atatf_pkg::MODE_CHS;
    end
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Reciprocal multiply for addr / 63
  assign prod = atatf_pkg::PROD_W'(s1_addr_r[atatf_pkg::LBA28_W-1:0])
              * atatf_pkg::PROD_W'(atatf_pkg::RECIP63);

  // Stage payloads
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_addr_r  <= in_block_address;
      s1_count_r <= in_sector_count;
      s1_wr_r    <= in_is_write;
      s1_drv_r   <= in_drive_select;
      s1_ch_r    <= in_channel_select;
      s1_mode_r  <= in_mode;
    end
    if (s2_ready) begin
      s2_addr_r  <= s1_addr_r;
      s2_count_r <= s1_count_r;
      s2_wr_r    <= s1_wr_r;
      s2_drv_r   <= s1_drv_r;
      s2_ch_r    <= s1_ch_r;
      s2_mode_r  <= s1_mode_r;
      s2_quot_r  <= prod[atatf_pkg::PROD_W-1:atatf_pkg::RECIP_SHIFT];
    end
  end

  // CHS split: sector = addr - 63*q + 1, head = q mod 16, cylinder = q / 16
  assign rem = s2_addr_r[atatf_pkg::LBA28_W-1:0]
             - (atatf_pkg::LBA28_W'({s2_quot_r, 6'b0})
                - atatf_pkg::LBA28_W'(s2_quot_r));
  assign sector = {2'b00, rem[5:0]} + 8'd1;

  // Build the task-file bytes
  always_comb begin
    cmd         = '0;
    cmd.channel = s2_ch_r;
    cmd.mode    = s2_mode_r;
    cmd.count   = s2_count_r;
    head        = 4'd0;
    case (s2_mode_r)
      atatf_pkg::MODE_LBA48: begin
        cmd.lba0 = s2_addr_r[7:0];
        cmd.lba1 = s2_addr_r[15:8];
        cmd.lba2 = s2_addr_r[23:16];
        cmd.lba3 = s2_addr_r[31:24];
        cmd.lba4 = s2_addr_r[39:32];
        cmd.lba5 = s2_addr_r[47:40];
      end
      atatf_pkg::MODE_LBA28: begin
        cmd.lba0 = s2_addr_r[7:0];
        cmd.lba1 = s2_addr_r[15:8];
        cmd.lba2 = s2_addr_r[23:16];
        head     = s2_addr_r[27:24];
      end
      default: begin
        cmd.lba0 = sector;
        cmd.lba1 = s2_quot_r[11:4];
        cmd.lba2 = s2_quot_r[19:12];
        head     = s2_quot_r[3:0];
      end
    endcase
    cmd.select = ((s2_mode_r == atatf_pkg::MODE_CHS) ? atatf_pkg::SEL_CHS
                                                      : atatf_pkg::SEL_LBA)
               | {3'b000, s2_drv_r, head};
    if (s2_mode_r == atatf_pkg::MODE_LBA48) begin
      cmd.opcode = s2_wr_r ? atatf_pkg::CMD_WRITE_EXT : atatf_pkg::CMD_READ_EXT;
    end else begin
      cmd.opcode = s2_wr_r ? atatf_pkg::CMD_WRITE : atatf_pkg::CMD_READ;
    end
  end

  assign cmd_valid = s2_valid_r;

endmodule

// ----- design/atatf_sequencer.sv -----
// ----------------------------------------------------------------------------
// ATA task-file write sequencer
// Holds one decoded command and steps its writes into the output register,
// one per cycle unless stalled. Loads the next command on the last write.
// ----------------------------------------------------------------------------
module atatf_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  atatf_pkg::cmd_t                 cmd,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_port_channel,
  output logic                            out_port_block,
  output logic [atatf_pkg::OFF_W-1:0]     out_port_offset,
  output logic [atatf_pkg::BYTE_W-1:0]    out_write_data,
  output logic                            out_last_write
);

  logic                            busy_r;
  logic                            busy_nxt;
  atatf_pkg::step_t                step_r;
  atatf_pkg::step_t                step_nxt;
  atatf_pkg::cmd_t                 cmd_r;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic                            out_channel_r;
  logic                            out_block_r;
  logic [atatf_pkg::OFF_W-1:0]     out_offset_r;
  logic [atatf_pkg::BYTE_W-1:0]    out_data_r;
  logic                            out_last_r;

  logic                            out_adv;
  logic                            emit;
  logic                            run_done;
  logic                            load;
  logic                            wr_block;
  logic [atatf_pkg::OFF_W-1:0]     wr_offset;
  logic [atatf_pkg::BYTE_W-1:0]    wr_data;
  logic                            wr_last;

  // Output register frees up when empty or being taken
  assign out_adv   = !out_valid_r || out_ready;
  assign emit      = busy_r && out_adv;
  assign run_done  = emit && (step_r == atatf_pkg::STP_CMD);
  assign cmd_ready = !busy_r || run_done;
  assign load      = cmd_valid && cmd_ready;

  // Register write for the current step
  always_comb begin
    wr_block  = atatf_pkg::BLK_CMD;
    wr_offset = atatf_pkg::OFF_SECCOUNT;
    wr_data   = '0;
    wr_last   = 1'b0;
    case (step_r)
      atatf_pkg::STP_NIEN, atatf_pkg::STP_LOB_CNT, atatf_pkg::STP_LOB_L3,
      atatf_pkg::STP_LOB_L4, atatf_pkg::STP_LOB_L5: begin
        wr_block  = atatf_pkg::BLK_CTRL;
        wr_offset = atatf_pkg::OFF_DEV_CTRL;
        wr_data   = atatf_pkg::CTRL_NIEN;
      end
      atatf_pkg::STP_HOB_CNT, atatf_pkg::STP_HOB_L3, atatf_pkg::STP_HOB_L4,
      atatf_pkg::STP_HOB_L5: begin
        wr_block  = atatf_pkg::BLK_CTRL;
        wr_offset = atatf_pkg::OFF_DEV_CTRL;
        wr_data   = atatf_pkg::CTRL_HOB_NIEN;
      end
      atatf_pkg::STP_SELECT: begin
        wr_offset = atatf_pkg::OFF_DRV_HEAD;
        wr_data   = cmd_r.select;
      end
      atatf_pkg::STP_HI_CNT: begin
        wr_offset = atatf_pkg::OFF_SECCOUNT;
        wr_data   = '0;
      end
      atatf_pkg::STP_HI_L3: begin
        wr_offset = atatf_pkg::OFF_LBA0;
        wr_data   = cmd_r.lba3;
      end
      atatf_pkg::STP_HI_L4: begin
        wr_offset = atatf_pkg::OFF_LBA1;
        wr_data   = cmd_r.lba4;
      end
      atatf_pkg::STP_HI_L5: begin
        wr_offset = atatf_pkg::OFF_LBA2;
        wr_data   = cmd_r.lba5;
      end
      atatf_pkg::STP_COUNT: begin
        wr_offset = atatf_pkg::OFF_SECCOUNT;
        wr_data   = cmd_r.count;
      end
      atatf_pkg::STP_LBA0: begin
        wr_offset = atatf_pkg::OFF_LBA0;
        wr_data   = cmd_r.lba0;
      end
      atatf_pkg::STP_LBA1: begin
        wr_offset = atatf_pkg::OFF_LBA1;
        wr_data   = cmd_r.lba1;
      end
      atatf_pkg::STP_LBA2: begin
        wr_offset = atatf_pkg::OFF_LBA2;
        wr_data   = cmd_r.lba2;
      end
      atatf_pkg::STP_CMD: begin
        wr_offset = atatf_pkg::OFF_COMMAND;
        wr_data   = cmd_r.opcode;
        wr_last   = 1'b1;
      end
      default: begin
        wr_block  = atatf_pkg::BLK_CMD;
        wr_offset = atatf_pkg::OFF_SECCOUNT;
        wr_data   = '0;
        wr_last   = 1'b0;
      end
    endcase
  end

  // Advance the step; skip the high-order block outside 48-bit mode
  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_adv) begin
      out_valid_nxt = busy_r;
    end
    if (emit) begin
      if (step_r == atatf_pkg::STP_SELECT && cmd_r.mode != atatf_pkg::MODE_LBA48) begin
        step_nxt = atatf_pkg::STP_COUNT;
      end else begin
        step_nxt = atatf_pkg::step_t'(5'(step_r + 5'd1));
      end
    end
    if (run_done) begin
      busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      step_nxt = atatf_pkg::STP_NIEN;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= atatf_pkg::STP_NIEN;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the command; latch each write into the output register
  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= cmd;
    end
    if (emit) begin
      out_channel_r <= cmd_r.channel;
      out_block_r   <= wr_block;
      out_offset_r  <= wr_offset;
      out_data_r    <= wr_data;
      out_last_r    <= wr_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_port_channel = out_channel_r;
  assign out_port_block   = out_block_r;
  assign out_port_offset  = out_offset_r;
  assign out_write_data   = out_data_r;
  assign out_last_write   = out_last_r;

endmodule

// ----- design/ata_taskfile_command_issuer_unit.sv -----
// ----------------------------------------------------------------------------
// ATA task-file command issuer
// Turns one PIO transfer request into the ordered run of task-file register
// writes (control, drive/head, 48-bit high bytes, count, LBA, command).
//
//   channel   direction  handshake          transfer
//   in_*      input      in_valid/ready     one transfer request
//   out_*     output     out_valid/ready    one task-file register write
//   cfg_*     input      cfg_wr_en          per-drive LBA capable mask
//
// A run is 7 register writes (CHS, LBA28) or 19 (LBA48), one write per cycle
// while out_ready allows, set by the sequencer's single write port. Runs
// follow back to back: the next request is decoded while the current run is
// still going out. A stall on out_ready holds the run and backs up into
// in_ready. Synchronous reset clears the mask and empties every stage.
// ----------------------------------------------------------------------------
module ata_taskfile_command_issuer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [atatf_pkg::MASK_W-1:0]    cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [atatf_pkg::ADDR_W-1:0]    in_block_address,
  input  logic [atatf_pkg::COUNT_W-1:0]   in_sector_count,
  input  logic                            in_is_write,
  input  logic                            in_drive_select,
  input  logic                            in_channel_select,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_port_channel,
  output logic                            out_port_block,
  output logic [atatf_pkg::OFF_W-1:0]     out_port_offset,
  output logic [atatf_pkg::BYTE_W-1:0]    out_write_data,
  output logic                            out_last_write
);

  logic [atatf_pkg::MASK_W-1:0] lba_capable_mask_r;
  logic                         cmd_valid;
  logic                         cmd_ready;
  atatf_pkg::cmd_t              cmd;

  // LBA capable mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lba_capable_mask_r <= '0;
    end else if (cfg_wr_en) begin
      lba_capable_mask_r <= cfg_wr_data;
    end
  end

  atatf_decode u_decode (
    .clk               (clk),
    .rst_n             (rst_n),
    .lba_capable_mask  (lba_capable_mask_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_block_address  (in_block_address),
    .in_sector_count   (in_sector_count),
    .in_is_write       (in_is_write),
    .in_drive_select   (in_drive_select),
    .in_channel_select (in_channel_select),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .cmd               (cmd)
  );

  atatf_sequencer u_sequencer (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_port_channel (out_port_channel),
    .out_port_block   (out_port_block),
    .out_port_offset  (out_port_offset),
    .out_write_data   (out_write_data),
    .out_last_write   (out_last_write)
  );

endmodule

// ----- sim/ata_taskfile_command_issuer_unit_test.sv -----
// ----------------------------------------------------------------------------
// ATA task-file command issuer testbench
// Sends PIO transfer requests through the valid/ready input channel and
// checks every task-file register write against a run predicted here from
// the request and the LBA capable mask. Covers CHS, LBA28 and LBA48 runs,
// directed address extremes, random traffic with idling on both sides and
// one long output hold-off that backs up into the input.
// ----------------------------------------------------------------------------
module ata_taskfile_command_issuer_unit_test;
  import atatf_pkg::*;

  localparam int SECTORS_PER_TRACK = 63;
  localparam int HEADS_PER_CYL     = 16;
  localparam int SETTLE_CYCLES     = 30;
  localparam int LONG_HOLD_CYCLES  = 400;
  localparam int RANDOM_PER_PHASE  = 50;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    logic               is_write;
    logic               drive;
    logic               channel;
  } request_t;

  typedef struct packed {
    logic              channel;
    logic              blk;
    logic [OFF_W-1:0]  offset;
    logic [BYTE_W-1:0] data;
    logic              last;
  } reg_write_t;

  // Predicts the register writes of each request and checks the block's writes
  class taskfile_run_checker;
    reg_write_t       expected_writes[$];
    logic [MASK_W-1:0] lba_mask;
    int               errors;
    int               writes_checked;
    int               runs_chs;
    int               runs_lba28;
    int               runs_lba48;

    function void set_mask(logic [MASK_W-1:0] m);
      lba_mask = m;
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction

    function void push_write(logic ch, logic blk, logic [OFF_W-1:0] off,
                             logic [BYTE_W-1:0] data, logic last);
      reg_write_t w;
      w.channel = ch;
      w.blk     = blk;
      w.offset  = off;
      w.data    = data;
      w.last    = last;
      expected_writes.push_back(w);
    endfunction

    // Build the full write run of one accepted request
    function void add_request_run(request_t r);
      logic [BYTE_W-1:0] lba [6];
      logic [BYTE_W-1:0] hi_byte [4];
      logic [OFF_W-1:0]  hi_off [4];
      logic [3:0]        head;
      logic [15:0]       cyl;
      logic [BYTE_W-1:0] sel;
      logic [BYTE_W-1:0] opcode;
      mode_t             mode;
      if (r.addr >= (48'd1 << LBA28_W)) begin
        mode = MODE_LBA48;
        for (int i = 0; i < 6; i++) lba[i] = r.addr[8*i +: 8];
        head = '0;
        runs_lba48++;
      end else if (lba_mask[{r.channel, r.drive}]) begin
        mode = MODE_LBA28;
        for (int i = 0; i < 3; i++) lba[i] = r.addr[8*i +: 8];
        lba[3] = '0;
        lba[4] = '0;
        lba[5] = '0;
        head = r.addr[27:24];
        runs_lba28++;
      end else begin
        mode = MODE_CHS;
        cyl = 16'(r.addr / (SECTORS_PER_TRACK * HEADS_PER_CYL));
        lba[0] = 8'(r.addr % SECTORS_PER_TRACK + 1);
        lba[1] = cyl[7:0];
        lba[2] = cyl[15:8];
        lba[3] = '0;
        lba[4] = '0;
        lba[5] = '0;
        head = 4'((r.addr / SECTORS_PER_TRACK) % HEADS_PER_CYL);
        runs_chs++;
      end

      push_write(r.channel, BLK_CTRL, OFF_DEV_CTRL, CTRL_NIEN, 1'b0);
      sel = (mode == MODE_CHS) ? SEL_CHS : SEL_LBA;
      sel = sel | {3'b000, r.drive, head};
      push_write(r.channel, BLK_CMD, OFF_DRV_HEAD, sel, 1'b0);

      // High-order bytes, each bracketed by HOB set and cleared
      if (mode == MODE_LBA48) begin
        hi_byte[0] = '0;
        hi_byte[1] = lba[3];
        hi_byte[2] = lba[4];
        hi_byte[3] = lba[5];
        hi_off[0]  = OFF_SECCOUNT;
        hi_off[1]  = OFF_LBA0;
        hi_off[2]  = OFF_LBA1;
        hi_off[3]  = OFF_LBA2;
        for (int i = 0; i < 4; i++) begin
          push_write(r.channel, BLK_CTRL, OFF_DEV_CTRL, CTRL_HOB_NIEN, 1'b0);
          push_write(r.channel, BLK_CMD, hi_off[i], hi_byte[i], 1'b0);
          push_write(r.channel, BLK_CTRL, OFF_DEV_CTRL, CTRL_NIEN, 1'b0);
        end
      end

      push_write(r.channel, BLK_CMD, OFF_SECCOUNT, r.count, 1'b0);
      push_write(r.channel, BLK_CMD, OFF_LBA0, lba[0], 1'b0);
      push_write(r.channel, BLK_CMD, OFF_LBA1, lba[1], 1'b0);
      push_write(r.channel, BLK_CMD, OFF_LBA2, lba[2], 1'b0);
      if (mode == MODE_LBA48) opcode = r.is_write ? CMD_WRITE_EXT : CMD_READ_EXT;
      else                    opcode = r.is_write ? CMD_WRITE : CMD_READ;
      push_write(r.channel, BLK_CMD, OFF_COMMAND, opcode, 1'b1);
    endfunction

    task report(string what, int unsigned want, int unsigned seen);
      errors++;
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
               $realtime, what, want, seen);
    endtask

    // Compare one transferred write with the oldest expected one
    task check_write(reg_write_t got);
      reg_write_t want;
      writes_checked++;
      if (expected_writes.size() == 0) begin
        report("unexpected write (offset/data)", 0, {got.offset, got.data});
      end else begin
        want = expected_writes.pop_front();
        if (got.channel !== want.channel) report("port_channel", want.channel, got.channel);
        if (got.blk !== want.blk)         report("port_block", want.blk, got.blk);
        if (got.offset !== want.offset)   report("port_offset", want.offset, got.offset);
        if (got.data !== want.data)       report("write_data", want.data, got.data);
        if (got.last !== want.last)       report("last_write", want.last, got.last);
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [MASK_W-1:0]    cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ADDR_W-1:0]    in_block_address = '0;
  logic [COUNT_W-1:0]   in_sector_count = '0;
  logic                 in_is_write = 1'b0;
  logic                 in_drive_select = 1'b0;
  logic                 in_channel_select = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_port_channel;
  logic                 out_port_block;
  logic [OFF_W-1:0]     out_port_offset;
  logic [BYTE_W-1:0]    out_write_data;
  logic                 out_last_write;

  taskfile_run_checker board = new();
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  requests_sent = 0;

  ata_taskfile_command_issuer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_block_address  (in_block_address),
    .in_sector_count   (in_sector_count),
    .in_is_write       (in_is_write),
    .in_drive_select   (in_drive_select),
    .in_channel_select (in_channel_select),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_port_channel  (out_port_channel),
    .out_port_block    (out_port_block),
    .out_port_offset   (out_port_offset),
    .out_write_data    (out_write_data),
    .out_last_write    (out_last_write)
  );

  // Free-running clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  // Check each write transfer and pace out_ready, with one long hold-off
  initial begin
    reg_write_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.channel = out_port_channel;
        got.blk     = out_port_block;
        got.offset  = out_port_offset;
        got.data    = out_write_data;
        got.last    = out_last_write;
        board.check_write(got);
      end
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic request_t make_req(logic [ADDR_W-1:0] a, logic [COUNT_W-1:0] c,
                                        logic w, logic d, logic ch);
    request_t r;
    r.addr     = a;
    r.count    = c;
    r.is_write = w;
    r.drive    = d;
    r.channel  = ch;
    return r;
  endfunction

  // Offer one request, idling first at random, and hold it until transfer
  task automatic send_request(request_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_block_address  <= r.addr;
    in_sector_count   <= r.count;
    in_is_write       <= r.is_write;
    in_drive_select   <= r.drive;
    in_channel_select <= r.channel;
    do @(posedge clk); while (!in_ready);
    board.add_request_run(r);
    requests_sent++;
  endtask

  // Drop valid and wait until every expected write has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(logic [MASK_W-1:0] m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_mask(m);
  endtask

  // Random requests: full 48-bit, below the LBA48 limit, CHS range, low, edges
  task automatic send_random(int n);
    request_t r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: begin
          r.addr[47:32] = 16'($urandom_range(0, 16'hFFFF));
          r.addr[31:0]  = $urandom();
        end
        1: r.addr = 48'($urandom_range(0, (1 << LBA28_W) - 1));
        2: r.addr = 48'($urandom_range(0, 1008 * 65536 - 1));
        3: r.addr = 48'($urandom_range(0, 4095));
        default: begin
          case ($urandom_range(0, 3))
            0: r.addr = (48'd1 << LBA28_W) + 48'($urandom_range(0, 3));
            1: r.addr = (48'd1 << LBA28_W) - 48'($urandom_range(1, 4));
            2: r.addr = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3));
            default: r.addr = 48'(1008 * 65536) + 48'($urandom_range(0, 1100));
          endcase
        end
      endcase
      r.count    = 8'($urandom_range(0, 255));
      r.is_write = 1'($urandom_range(0, 1));
      r.drive    = 1'($urandom_range(0, 1));
      r.channel  = 1'($urandom_range(0, 1));
      send_request(r);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, CHS by default: sector, head and cylinder edges
    write_mask(4'h0);
    send_request(make_req(48'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send_request(make_req(48'd62, 8'd255, 1'b1, 1'b1, 1'b0));
    send_request(make_req(48'd63, 8'd1, 1'b0, 1'b0, 1'b1));
    send_request(make_req(48'd1007, 8'd8, 1'b1, 1'b1, 1'b1));
    send_request(make_req(48'(1008 * 65536), 8'd16, 1'b0, 1'b0, 1'b0));
    send_request(make_req(48'h0FFF_FFFF, 8'd128, 1'b1, 1'b1, 1'b1));
    send_request(make_req(48'h1000_0000, 8'd2, 1'b0, 1'b0, 1'b0));
    send_request(make_req(48'hFFFF_FFFF_FFFF, 8'd255, 1'b1, 1'b1, 1'b1));
    drain();

    // Directed, every drive LBA capable
    write_mask(4'hF);
    send_request(make_req(48'd0, 8'd1, 1'b0, 1'b0, 1'b0));
    send_request(make_req(48'h0FFF_FFFF, 8'd255, 1'b1, 1'b1, 1'b0));
    send_request(make_req(48'h00AB_CDEF, 8'd0, 1'b0, 1'b0, 1'b1));
    send_request(make_req(48'h1000_0000, 8'd7, 1'b1, 1'b1, 1'b1));
    send_request(make_req(48'hFFFF_FFFF_FFFF, 8'd0, 1'b0, 1'b0, 1'b1));
    send_request(make_req(48'h1234_5678_9ABC, 8'd42, 1'b1, 1'b1, 1'b0));
    drain();

    // Directed, mixed masks: each drive on each channel
    write_mask(4'h5);
    for (int i = 0; i < 4; i++)
      send_request(make_req(48'h0123_4567, 8'(i), 1'(i), 1'(i), 1'(i >> 1)));
    drain();
    write_mask(4'h6);
    for (int i = 0; i < 4; i++)
      send_request(make_req(48'h0765_4321, 8'(i + 200), 1'(~i), 1'(i), 1'(i >> 1)));
    drain();

    // Random, sender idles less than the receiver
    write_mask(4'($urandom_range(0, 15)));
    tx_idle_pct = 36;
    rx_idle_pct = 57;
    send_random(RANDOM_PER_PHASE);
    drain();

    // Random, the other way round
    write_mask(4'($urandom_range(0, 15)));
    tx_idle_pct = 57;
    rx_idle_pct = 36;
    send_random(RANDOM_PER_PHASE);
    drain();

    // Random at full rate, opening with a long output hold-off
    write_mask(4'($urandom_range(0, 15)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    send_random(RANDOM_PER_PHASE);
    drain();

    $display("Covered %0d requests (%0d CHS, %0d LBA28, %0d LBA48), %0d writes checked,",
             requests_sent, board.runs_chs, board.runs_lba28, board.runs_lba48,
             board.writes_checked);
    $display("over several drive masks, idling on both sides and a long output stall.");
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/atatf_pkg.sv
design/atatf_decode.sv
design/atatf_sequencer.sv
design/ata_taskfile_command_issuer_unit.sv
sim/ata_taskfile_command_issuer_unit_test.sv
